// ===== rtl/erm_pkg.sv =====
// Shared types and codes for the extent record mapper.
package erm_pkg;

    typedef enum logic [1:0] {
        ACT_EXTENT_WR = 2'd0,
        ACT_HEADER_WR = 2'd1,
        ACT_TRANSLATE = 2'd2,
        ACT_CLEAR_ALL = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMOUNTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_DISPATCH = 2'd1,
        S_WALK     = 2'd2,
        S_ADDR     = 2'd3
    } seq_state_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    typedef struct packed {
        action_t     action;
        logic        unit;
        logic [3:0]  extent_index;
        logic [31:0] start_block;
        logic [31:0] block_count;
        logic [1:0]  mount_mode;
        logic [4:0]  extent_total;
        logic [31:0] record_total;
        logic [31:0] relative_record;
    } erm_in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] absolute_record;
        logic        directory_head;
    } erm_out_t;

    typedef struct packed {
        logic [31:0] start_block;
        logic [31:0] block_count;
    } ext_entry_t;

endpackage

// ===== rtl/extent_record_mapper_top.sv =====
// Extent record mapper: unit headers, sequencer and result register.
//
// An item is taken when start is high and busy is low; its result comes back
// as a one-cycle beat on result, flagged by done, and must be taken in that
// cycle. Extent writes, header writes and clear-all finish in the dispatch
// state. So does a translation that fails the mount or range check or whose
// unit has no extents; any other translation walks the unit's extents in
// order and, on a hit, forms the address in a final add state.
// The walk reads one table entry per cycle through the extent memory's single
// read port and runs each step through one shared add/subtract unit. busy
// falls in the cycle the result beat is shown, so the next item can be taken
// alongside it. No clearing pass after reset; extent entries hold garbage
// until written.
module extent_record_mapper_top
    import erm_pkg::*;
#(
    parameter int UNITS        = 2,
    parameter int MAX_EXTENTS  = 16,
    parameter int RECORD_SHIFT = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  erm_in_t  item,
    output logic     busy,
    output logic     done,
    output erm_out_t result
);

    localparam int UNIT_W = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
    localparam int DEPTH  = UNITS * MAX_EXTENTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] LOW_MASK = (32'd1 << RECORD_SHIFT) - 32'd1;

    seq_state_t state_reg;
    seq_state_t state_next;

    erm_in_t     item_reg;
    logic [31:0] blk_reg;
    logic [31:0] start_reg;
    logic [CNT_W-1:0] idx_reg;

    logic [1:0]       mode_reg    [UNITS];
    logic [CNT_W-1:0] ext_cnt_reg [UNITS];
    logic [31:0]      rec_cnt_reg [UNITS];

    logic     done_reg;
    erm_out_t result_reg;

    // decoded item
    logic              unit_ok;
    logic              index_ok;
    logic [UNIT_W-1:0] unit_idx;
    logic [1:0]        cur_mode;
    logic [CNT_W-1:0]  cur_ext_cnt;
    logic [31:0]       cur_rec_cnt;
    logic [31:0]       tot_sat;
    logic [CNT_W-1:0]  idx_plus;
    logic              last_extent;

    // shared unit
    alu_op_t     alu_op;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic [31:0] alu_sum;
    logic        alu_carry;

    // table
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wr_addr;
    ext_entry_t        mem_wr_data;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_rd_addr;
    ext_entry_t        mem_rd_data;
    logic [31:0]       rd_idx;

    // sequencer controls
    logic     hdr_we;
    logic     hdr_clear;
    logic     walk_begin;
    logic     walk_step;
    logic     start_load;
    logic     fin;
    erm_out_t fin_result;
    logic     accept;

    assign accept = start && (state_reg == S_IDLE);

    assign unit_ok     = (32'(item_reg.unit) < UNITS);
    assign index_ok    = (32'(item_reg.extent_index) < MAX_EXTENTS);
    assign unit_idx    = unit_ok ? UNIT_W'(item_reg.unit) : '0;
    assign cur_mode    = mode_reg[unit_idx];
    assign cur_ext_cnt = ext_cnt_reg[unit_idx];
    assign cur_rec_cnt = rec_cnt_reg[unit_idx];
    assign tot_sat     = (32'(item_reg.extent_total) > MAX_EXTENTS) ?
                         32'(MAX_EXTENTS) : 32'(item_reg.extent_total);
    assign idx_plus    = idx_reg + CNT_W'(1);
    assign last_extent = (idx_plus == cur_ext_cnt);

    assign mem_wr_addr = ADDR_W'(32'(unit_idx) * MAX_EXTENTS + 32'(item_reg.extent_index));
    assign mem_wr_data = '{start_block: item_reg.start_block,
                           block_count: item_reg.block_count};
    assign rd_idx      = (state_reg == S_WALK) ? 32'(idx_plus) : 32'd0;
    assign mem_rd_addr = ADDR_W'(32'(unit_idx) * MAX_EXTENTS + rd_idx);

    erm_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    erm_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // shared unit operand select
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = item_reg.relative_record;
        alu_b  = cur_rec_cnt;
        case (state_reg)
            S_WALK:
            begin
                alu_a = blk_reg;
                alu_b = mem_rd_data.block_count;
            end
            S_ADDR:
            begin
                alu_op = ALU_ADD;
                alu_a  = start_reg;
                alu_b  = blk_reg;
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (walk_begin)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (!alu_carry)
                begin
                    state_next = S_ADDR;
                end
                else if (last_extent)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADDR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        hdr_we     = 1'b0;
        hdr_clear  = 1'b0;
        walk_begin = 1'b0;
        walk_step  = 1'b0;
        start_load = 1'b0;
        fin        = 1'b0;
        fin_result = '{status: ST_OK, absolute_record: 32'd0, directory_head: 1'b0};
        case (state_reg)
            S_DISPATCH:
            begin
                case (item_reg.action)
                    ACT_EXTENT_WR:
                    begin
                        mem_we = unit_ok && index_ok;
                        fin    = 1'b1;
                    end
                    ACT_HEADER_WR:
                    begin
                        hdr_we = unit_ok;
                        fin    = 1'b1;
                    end
                    ACT_CLEAR_ALL:
                    begin
                        hdr_clear = 1'b1;
                        fin       = 1'b1;
                    end
                    default:
                    begin
                        if (!unit_ok || (cur_mode == MODE_NONE))
                        begin
                            fin               = 1'b1;
                            fin_result.status = ST_UNMOUNTED;
                        end
                        else if (alu_carry)
                        begin
                            // record >= record count
                            fin               = 1'b1;
                            fin_result.status = ST_RANGE;
                        end
                        else if (cur_ext_cnt == '0)
                        begin
                            fin               = 1'b1;
                            fin_result.status = ST_EXHAUSTED;
                        end
                        else
                        begin
                            walk_begin = 1'b1;
                            mem_re     = 1'b1;
                        end
                    end
                endcase
            end
            S_WALK:
            begin
                if (!alu_carry)
                begin
                    start_load = 1'b1;
                end
                else if (last_extent)
                begin
                    fin               = 1'b1;
                    fin_result.status = ST_EXHAUSTED;
                end
                else
                begin
                    walk_step = 1'b1;
                    mem_re    = 1'b1;
                end
            end
            S_ADDR:
            begin
                fin = 1'b1;
                fin_result.absolute_record = (alu_sum << RECORD_SHIFT) |
                                             (item_reg.relative_record & LOW_MASK);
                fin_result.directory_head  =
                    ((item_reg.relative_record >> RECORD_SHIFT) == 32'd0);
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (walk_begin)
            begin
                idx_reg <= '0;
            end
            else if (walk_step)
            begin
                idx_reg <= idx_plus;
            end
        end
    end

    // per-item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (walk_begin)
        begin
            blk_reg <= item_reg.relative_record >> RECORD_SHIFT;
        end
        else if (walk_step)
        begin
            blk_reg <= alu_sum;
        end
        if (start_load)
        begin
            start_reg <= mem_rd_data.start_block;
        end
        if (fin)
        begin
            result_reg <= fin_result;
        end
    end

    // unit headers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < UNITS; u++)
            begin
                mode_reg[u]    <= MODE_NONE;
                ext_cnt_reg[u] <= '0;
                rec_cnt_reg[u] <= '0;
            end
        end
        else if (hdr_clear)
        begin
            for (int u = 0; u < UNITS; u++)
            begin
                mode_reg[u]    <= MODE_NONE;
                ext_cnt_reg[u] <= '0;
                rec_cnt_reg[u] <= '0;
            end
        end
        else if (hdr_we)
        begin
            mode_reg[unit_idx]    <= (item_reg.mount_mode == MODE_INVALID) ?
                                     MODE_NONE : item_reg.mount_mode;
            ext_cnt_reg[unit_idx] <= CNT_W'(tot_sat);
            rec_cnt_reg[unit_idx] <= item_reg.record_total;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (idx_reg < cur_ext_cnt))
        else $error("extent walk ran past the unit's extent count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |->
            ((result.absolute_record == 32'd0) && !result.directory_head))
        else $error("failed translation carries a nonzero record");

endmodule

// ===== rtl/erm_alu.sv =====
// Shared 32-bit add/subtract unit; carry out doubles as the a >= b compare.
module erm_alu
    import erm_pkg::*;
(
    input  alu_op_t     op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum,
    output logic        carry
);

    logic [32:0] full;

    always_comb
    begin
        if (op == ALU_SUB)
        begin
            full = {1'b0, a} + {1'b0, ~b} + 33'd1;
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign sum   = full[31:0];
    assign carry = full[32];

endmodule

// ===== rtl/erm_table.sv =====
// Extent table memory: one write port, one registered read port.
module erm_table
    import erm_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  ext_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output ext_entry_t        rd_data
);

    ext_entry_t mem [DEPTH];
    ext_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/tb_extent_record_mapper_top.sv =====
// Testbench for the extent record mapper: queued command driver, result monitor and predictor.
`timescale 1ns / 1ps

module tb_extent_record_mapper_top;
    import erm_pkg::*;

    localparam int UNIT_CNT   = 2;
    localparam int MAX_EXT    = 16;
    localparam int REC_SHIFT  = 2;
    localparam logic [31:0] LOW_MASK = (32'd1 << REC_SHIFT) - 32'd1;
    localparam int ITEM_TARGET = 1900;
    localparam int TAIL_ITEMS  = 150;
    localparam int WATCHDOG    = 3000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        erm_in_t req;
        int      gap;
        bit      drain;
    } pending_req_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    erm_in_t  item = '0;
    logic     busy;
    logic     done;
    erm_out_t result;

    extent_record_mapper_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [1:0]  vol_mode    [UNIT_CNT] = '{default: '0};
    logic [4:0]  vol_extents [UNIT_CNT] = '{default: '0};
    logic [31:0] vol_records [UNIT_CNT] = '{default: '0};
    logic [31:0] ext_first_block [UNIT_CNT*MAX_EXT] = '{default: '0};
    logic [31:0] ext_blocks      [UNIT_CNT*MAX_EXT] = '{default: '0};

    // stimulus-side view of the tables, so no translation walks an unwritten entry
    logic [1:0]  gen_mode    [UNIT_CNT] = '{default: '0};
    int          gen_count   [UNIT_CNT] = '{default: 0};
    bit          gen_written [UNIT_CNT*MAX_EXT] = '{default: 1'b0};

    pending_req_t queued_requests[$];
    erm_out_t     predicted_results[$];
    int  n_queued = 0;
    int  n_accepted = 0;
    int  mismatches = 0;
    int  stall_cycles = 0;
    bit  drain_next = 1'b0;
    bit  calm = 1'b0;
    int  calm_left = 40;

    pending_req_t cur;
    bit  holding = 1'b0;
    bit  fire;
    int  gap_left = 0;

    function automatic erm_out_t mapper_step(input erm_in_t req);
        erm_out_t    res;
        logic [31:0] blk;
        logic [31:0] addr;
        int          base;
        bit          hit;
        res = '0;
        res.status = ST_OK;
        base = req.unit * MAX_EXT;
        case (req.action)
            ACT_EXTENT_WR:
            begin
                ext_first_block[base + req.extent_index] = req.start_block;
                ext_blocks[base + req.extent_index] = req.block_count;
            end
            ACT_HEADER_WR:
            begin
                vol_mode[req.unit] = (req.mount_mode == MODE_INVALID) ? MODE_NONE : req.mount_mode;
                vol_extents[req.unit] = (req.extent_total > MAX_EXT) ? 5'(MAX_EXT)
                                                                      : req.extent_total;
                vol_records[req.unit] = req.record_total;
            end
            ACT_TRANSLATE:
            begin
                if (vol_mode[req.unit] == MODE_NONE)
                    res.status = ST_UNMOUNTED;
                else if (req.relative_record >= vol_records[req.unit])
                    res.status = ST_RANGE;
                else
                begin
                    blk = req.relative_record >> REC_SHIFT;
                    hit = 1'b0;
                    res.status = ST_EXHAUSTED;
                    for (int i = 0; i < vol_extents[req.unit]; i++)
                    begin
                        if (!hit)
                        begin
                            if (blk < ext_blocks[base + i])
                            begin
                                hit = 1'b1;
                                addr = ext_first_block[base + i] + blk;
                                res.status = ST_OK;
                                res.absolute_record = (addr << REC_SHIFT)
                                                    | (req.relative_record & LOW_MASK);
                                res.directory_head = (req.relative_record < (32'd1 << REC_SHIFT));
                            end
                            else
                                blk = blk - ext_blocks[base + i];
                        end
                    end
                end
            end
            default:
            begin
                for (int u = 0; u < UNIT_CNT; u++)
                begin
                    vol_mode[u] = MODE_NONE;
                    vol_extents[u] = '0;
                    vol_records[u] = '0;
                end
            end
        endcase
        return res;
    endfunction

    function automatic erm_in_t random_item();
        erm_in_t req;
        req.action          = action_t'($urandom_range(0, 3));
        req.unit            = 1'($urandom_range(0, 1));
        req.extent_index    = 4'($urandom_range(0, 15));
        req.start_block     = $urandom;
        req.block_count     = $urandom;
        req.mount_mode      = 2'($urandom_range(0, 3));
        req.extent_total    = 5'($urandom_range(0, 31));
        req.record_total    = $urandom;
        req.relative_record = $urandom;
        return req;
    endfunction

    function automatic logic [31:0] rand_below(input longint unsigned lim);
        return 32'({$urandom, $urandom} % lim);
    endfunction

    task automatic queue_item(input erm_in_t req);
        pending_req_t p;
        p.req = req;
        p.drain = drain_next;
        p.gap = (!calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
        drain_next = 1'b0;
        calm_left--;
        if (calm_left <= 0)
        begin
            calm = ~calm;
            calm_left = $urandom_range(20, 80);
        end
        case (req.action)
            ACT_EXTENT_WR:
                gen_written[req.unit * MAX_EXT + req.extent_index] = 1'b1;
            ACT_HEADER_WR:
            begin
                gen_mode[req.unit] = (req.mount_mode == MODE_INVALID) ? MODE_NONE
                                                                      : req.mount_mode;
                gen_count[req.unit] = (req.extent_total > MAX_EXT) ? MAX_EXT : req.extent_total;
            end
            ACT_CLEAR_ALL:
            begin
                for (int u = 0; u < UNIT_CNT; u++)
                begin
                    gen_mode[u] = MODE_NONE;
                    gen_count[u] = 0;
                end
            end
            default: ;
        endcase
        queued_requests.push_back(p);
        n_queued++;
    endtask

    task automatic queue_extent(input logic u, input logic [3:0] idx,
                                input logic [31:0] sb, input logic [31:0] bc);
        erm_in_t req;
        req = random_item();
        req.action = ACT_EXTENT_WR;
        req.unit = u;
        req.extent_index = idx;
        req.start_block = sb;
        req.block_count = bc;
        queue_item(req);
    endtask

    task automatic queue_header(input logic u, input logic [1:0] mode,
                                input logic [4:0] tot, input logic [31:0] rt);
        erm_in_t req;
        req = random_item();
        req.action = ACT_HEADER_WR;
        req.unit = u;
        req.mount_mode = mode;
        req.extent_total = tot;
        req.record_total = rt;
        queue_item(req);
    endtask

    // fills any entry the walk could reach that was never written
    task automatic queue_translate(input logic u, input logic [31:0] rec);
        erm_in_t req;
        if (gen_mode[u] != MODE_NONE)
        begin
            for (int i = 0; i < gen_count[u]; i++)
                if (!gen_written[u * MAX_EXT + i])
                    queue_extent(u, 4'(i), $urandom, $urandom_range(0, 4));
        end
        req = random_item();
        req.action = ACT_TRANSLATE;
        req.unit = u;
        req.relative_record = rec;
        queue_item(req);
    endtask

    // driver: one command beat per start/!busy edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            holding = 1'b0;
            gap_left = 0;
        end
        else
        begin
            fire = start && !busy;
            if (fire)
            begin
                predicted_results.push_back(mapper_step(item));
                n_accepted++;
            end
            if (!start || fire)
            begin
                if (!holding && queued_requests.size() > 0)
                begin
                    cur = queued_requests.pop_front();
                    holding = 1'b1;
                    gap_left = (queued_requests.size() < TAIL_ITEMS) ? 0 : cur.gap;
                end
                if (holding && gap_left == 0 && !(cur.drain && predicted_results.size() != 0))
                begin
                    start <= 1'b1;
                    item <= cur.req;
                    holding = 1'b0;
                end
                else
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        erm_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got status %0d rec %h head %b",
                             $time, result.status, result.absolute_record, result.directory_head);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, result.status);
                        mismatches++;
                    end
                    if (result.absolute_record !== want.absolute_record)
                    begin
                        $display("%0t: absolute_record mismatch, expected %h, got %h",
                                 $time, want.absolute_record, result.absolute_record);
                        mismatches++;
                    end
                    if (result.directory_head !== want.directory_head)
                    begin
                        $display("%0t: directory_head mismatch, expected %b, got %b",
                                 $time, want.directory_head, result.directory_head);
                        mismatches++;
                    end
                end
            end
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG)
            begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        erm_in_t           req;
        int                n_ext;
        int                scale;
        int                n_tr;
        int                j;
        logic [1:0]        mode;
        logic [4:0]        tot;
        logic [31:0]       len;
        logic [31:0]       sb;
        logic [31:0]       rt;
        logic [31:0]       rec;
        logic              u;
        longint unsigned   span;
        longint unsigned   lim;
        longint unsigned   prefix [MAX_EXT + 1];

        // directed: unmounted, invalid mode, wrap, zero-length extent, range edges
        queue_translate(1'b0, 32'd0);
        queue_header(1'b0, MODE_INVALID, 5'd31, 32'hFFFFFFFF);
        queue_translate(1'b0, 32'd0);
        queue_extent(1'b0, 4'd0, 32'hFFFFFFFF, 32'd2);
        queue_extent(1'b0, 4'd1, 32'h0, 32'h0);
        queue_extent(1'b0, 4'd2, 32'h40000000, 32'hFFFFFFFF);
        queue_extent(1'b0, 4'd15, 32'h12345678, 32'd1);
        queue_header(1'b0, 2'd1, 5'd3, 32'hFFFFFFFF);
        queue_translate(1'b0, 32'd0);
        queue_translate(1'b0, 32'd7);
        queue_translate(1'b0, 32'd8);
        queue_translate(1'b0, 32'hFFFFFFFE);
        queue_translate(1'b0, 32'hFFFFFFFF);
        queue_header(1'b1, 2'd2, 5'd0, 32'd100);
        queue_translate(1'b1, 32'd5);
        queue_extent(1'b1, 4'd0, 32'd10, 32'd1);
        queue_header(1'b1, 2'd2, 5'd1, 32'd100);
        queue_translate(1'b1, 32'd3);
        queue_translate(1'b1, 32'd4);
        req = random_item();
        req.action = ACT_CLEAR_ALL;
        queue_item(req);
        queue_translate(1'b1, 32'd3);
        // extent entries survive the clear
        queue_header(1'b0, 2'd1, 5'd3, 32'd16);
        queue_translate(1'b0, 32'd15);
        queue_header(1'b0, 2'd2, 5'd3, 32'd0);
        queue_translate(1'b0, 32'd0);

        drain_next = 1'b1;
        while (n_queued < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // noise: unrelated commands with random content
                repeat ($urandom_range(1, 4))
                begin
                    req = random_item();
                    if (req.action == ACT_TRANSLATE)
                        queue_translate(req.unit, req.relative_record);
                    else
                        queue_item(req);
                end
            end
            else
            begin
                // mount a unit with a fresh table, then translate across it
                if ($urandom_range(0, 49) == 0)
                    drain_next = 1'b1;
                u = 1'($urandom_range(0, 1));
                n_ext = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
                scale = $urandom_range(0, 3);
                prefix[0] = 0;
                for (int i = 0; i < n_ext; i++)
                begin
                    case (scale)
                        0: len = $urandom_range(0, 3);
                        1: len = $urandom_range(0, 40);
                        2: len = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8);
                        default: len = $urandom;
                    endcase
                    sb = ($urandom_range(0, 7) == 0) ? 32'hFFFFFFFF - $urandom_range(0, 63)
                                                      : $urandom;
                    queue_extent(u, 4'(i), sb, len);
                    prefix[i + 1] = prefix[i] + len;
                end
                span = prefix[n_ext] * 4;
                case ($urandom_range(0, 9))
                    8: tot = 5'($urandom_range(0, n_ext));
                    9: tot = 5'($urandom_range(n_ext, 31));
                    default: tot = 5'(n_ext);
                endcase
                case ($urandom_range(0, 4))
                    0: rt = $urandom;
                    1: rt = (span + 64 > 32'hFFFFFFFF) ? 32'hFFFFFFFF
                                                       : 32'(span + $urandom_range(1, 64));
                    default: rt = (span > 32'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(span);
                endcase
                case ($urandom_range(0, 19))
                    0: mode = MODE_NONE;
                    1: mode = MODE_INVALID;
                    default: mode = 2'($urandom_range(1, 2));
                endcase
                queue_header(u, mode, tot, rt);
                lim = (rt < span) ? rt : span;
                if (lim == 0)
                    lim = 1;
                n_tr = $urandom_range(4, 12);
                repeat (n_tr)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        req = random_item();
                        if (req.action == ACT_TRANSLATE)
                            queue_translate(req.unit, req.relative_record);
                        else
                            queue_item(req);
                    end
                    case ($urandom_range(0, 5))
                        0: rec = $urandom_range(0, 3);
                        1, 2: rec = rand_below(lim);
                        3:
                        begin
                            j = $urandom_range(0, n_ext);
                            rec = 32'(prefix[j] * 4 + $urandom_range(0, 7) - 4);
                        end
                        4: rec = rt + $urandom_range(0, 2) - 1;
                        default: rec = 32'(span + $urandom_range(0, 63));
                    endcase
                    queue_translate(u, rec);
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (n_accepted < n_queued || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
